// ===== sv/cbpm_pkg.sv =====
// cbpm_pkg: shared types and constants for the cursor buffer prefix-max block.
// Command and status codes, sequencer state, default sizes, sum width.
// No dependencies.
`timescale 1ns / 1ps

package cbpm_pkg;

	localparam int DEPTH_DEFAULT      = 1024;
	localparam int VALUE_BITS_DEFAULT = 16;
	localparam int SUM_BITS           = 26;
	localparam int CMD_BITS           = 3;
	localparam int STATUS_BITS        = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_LEFT   = 3'd2,
		CMD_RIGHT  = 3'd3,
		CMD_QUERY  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_DONE   = 3'd0,
		STAT_IDLE   = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_ANSWER = 3'd3,
		STAT_RANGE  = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Sequencer outputs toward the datapath
	typedef struct packed {
		logic busy;
		logic exec;
	} seq_ctl_t;

endpackage

// ===== sv/cbpm_ram.sv =====
// cbpm_ram: single-write, single-read synchronous RAM, registered read data.
// Used for both stacks. Depends on nothing.
`timescale 1ns / 1ps

module cbpm_ram #(
	parameter int WIDTH   = 16,
	parameter int ENTRIES = 1024,
	parameter int AW      = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [ENTRIES];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/cbpm_push_calc.sv =====
// cbpm_push_calc: new prefix sum (saturated) and prefix max for a left push.
// Depends on cbpm_pkg (SUM_BITS).
`timescale 1ns / 1ps

module cbpm_push_calc #(
	parameter int VALUE_BITS = cbpm_pkg::VALUE_BITS_DEFAULT,
	parameter int SW         = cbpm_pkg::SUM_BITS
) (
	input  logic signed [VALUE_BITS-1:0] push_value,
	input  logic                         has_prev,
	input  logic signed [SW-1:0]         prev_sum,
	input  logic signed [SW-1:0]         prev_best,
	output logic signed [SW-1:0]         new_sum,
	output logic signed [SW-1:0]         new_best
);
	import cbpm_pkg::*;

	localparam logic signed [SW:0] SAT_HI = (SW+1)'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
	localparam logic signed [SW:0] SAT_LO = (SW+1)'(-(64'sd1 <<< (SUM_BITS - 1)));

	logic signed [SW:0] v_ext;
	logic signed [SW:0] raw_sum;
	logic signed [SW:0] sat_sum;

	always_comb begin
		v_ext   = {{(SW + 1 - VALUE_BITS){push_value[VALUE_BITS-1]}}, push_value};
		raw_sum = {prev_sum[SW-1], prev_sum} + v_ext;
		if (raw_sum > SAT_HI) begin
			sat_sum = SAT_HI;
		end else if (raw_sum < SAT_LO) begin
			sat_sum = SAT_LO;
		end else begin
			sat_sum = raw_sum;
		end
		// first entry keeps the raw value, later ones the saturated sum
		new_sum = has_prev ? sat_sum[SW-1:0] : v_ext[SW-1:0];
		if (has_prev && (prev_best > new_sum)) begin
			new_best = prev_best;
		end else begin
			new_best = new_sum;
		end
	end

endmodule

// ===== sv/cbpm_seq.sv =====
// cbpm_seq: two-state sequencer, accept cycle then execute cycle.
// Depends on cbpm_pkg (state_t, seq_ctl_t).
`timescale 1ns / 1ps

module cbpm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output cbpm_pkg::seq_ctl_t ctl
);
	import cbpm_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE:  state_nx = start ? S_EXEC : S_IDLE;
			S_EXEC:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE: begin
				ctl.busy = 1'b0;
				ctl.exec = 1'b0;
			end
			S_EXEC: begin
				ctl.busy = 1'b1;
				ctl.exec = 1'b1;
			end
			default: begin
				ctl.busy = 1'b1;
				ctl.exec = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/cursor_buffer_prefix_max.sv =====
// cursor_buffer_prefix_max: sequence edited around a cursor, kept as two
// stacks in RAM, with running prefix sums and prefix maxima on the left.
// Depends on cbpm_pkg, cbpm_ram, cbpm_push_calc, cbpm_seq.
//
//   channel   | handshake          | fields
//   ----------+--------------------+---------------------------------
//   command   | start, busy        | command, value, query_index
//   result    | done (strobe)      | status, max_prefix
//
// For each command the accept edge issues the stack reads, and the next
// edge does the read-modify-write and loads the result register.
// done rises in the cycle after that; a new command can be accepted in that
// same cycle. busy is high during the execute cycle only, which keeps a
// read from overlapping the previous write.
// arst_n clears both stack counts, the sequencer and done; the RAMs need no
// clearing since only entries below a count are ever used.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module cursor_buffer_prefix_max #(
	parameter int DEPTH      = cbpm_pkg::DEPTH_DEFAULT,
	parameter int VALUE_BITS = cbpm_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [cbpm_pkg::CMD_BITS-1:0]          command,
	input  logic signed [VALUE_BITS-1:0]           value,
	input  logic [$clog2(DEPTH+1)-1:0]             query_index,
	output logic                                   done,
	output logic [cbpm_pkg::STATUS_BITS-1:0]       status,
	output logic signed [cbpm_pkg::SUM_BITS-1:0]   max_prefix
);
	import cbpm_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);  // stack counts, 0..DEPTH
	localparam int AW = $clog2(DEPTH);      // RAM address
	// sum storage: wide enough for a raw first value when VALUE_BITS > SUM_BITS
	localparam int SW = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;
	localparam int LW = VALUE_BITS + 2 * SW; // left entry: {value, sum, best}

	seq_ctl_t ctl;
	logic     accept;

	logic [CW-1:0] lc_q;
	logic [CW-1:0] rc_q;

	// execute-stage registers
	cmd_t                  cmd_s1;
	status_t               stat_s1;
	logic signed [VALUE_BITS-1:0] value_s1;
	logic                  has_prev_s1;

	// result register
	logic                  done_q;
	status_t               status_q;
	logic signed [SUM_BITS-1:0] max_prefix_q;

	// stack RAM ports
	logic            l_we;
	logic [AW-1:0]   l_waddr;
	logic [LW-1:0]   l_wdata;
	logic [AW-1:0]   l_raddr;
	logic [LW-1:0]   l_rdata;
	logic            r_we;
	logic [AW-1:0]   r_waddr;
	logic [VALUE_BITS-1:0] r_wdata;
	logic [AW-1:0]   r_raddr;
	logic [VALUE_BITS-1:0] r_rdata;

	// decode at accept
	cmd_t          cmd_in;
	status_t       stat_in;
	logic [CW-1:0] lc_m1;
	logic [CW-1:0] rc_m1;
	logic [CW-1:0] k_m1;
	logic [CW:0]   total;

	// execute datapath
	logic signed [VALUE_BITS-1:0] top_value;
	logic signed [SW-1:0]         top_sum;
	logic signed [SW-1:0]         top_best;
	logic signed [VALUE_BITS-1:0] push_value;
	logic signed [SW-1:0]         new_sum;
	logic signed [SW-1:0]         new_best;
	logic                         do_op;

	cbpm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctl    (ctl)
	);

	assign busy   = ctl.busy;
	assign accept = start && !ctl.busy;

	always_comb begin
		cmd_in = cmd_t'(command);
		lc_m1  = lc_q - CW'(1);
		rc_m1  = rc_q - CW'(1);
		k_m1   = query_index - CW'(1);
		total  = {1'b0, lc_q} + {1'b0, rc_q};
		case (cmd_in)
			CMD_INSERT: stat_in = (total >= (CW+1)'(DEPTH)) ? STAT_FULL : STAT_DONE;
			CMD_DELETE: stat_in = (lc_q != '0) ? STAT_DONE : STAT_IDLE;
			CMD_LEFT:   stat_in = (lc_q != '0) ? STAT_DONE : STAT_IDLE;
			CMD_RIGHT:  stat_in = (rc_q != '0) ? STAT_DONE : STAT_IDLE;
			CMD_QUERY:  stat_in = ((query_index != '0) && (query_index <= lc_q)) ?
				STAT_ANSWER : STAT_RANGE;
			default:    stat_in = STAT_IDLE;
		endcase
		// query reads entry k-1, every other command reads the top of stack
		l_raddr = (cmd_in == CMD_QUERY) ? k_m1[AW-1:0] : lc_m1[AW-1:0];
		r_raddr = rc_m1[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd_in;
			stat_s1     <= stat_in;
			value_s1    <= value;
			has_prev_s1 <= (lc_q != '0);
		end
	end

	cbpm_ram #(
		.WIDTH   (LW),
		.ENTRIES (DEPTH),
		.AW      (AW)
	) u_left_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (accept),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	cbpm_ram #(
		.WIDTH   (VALUE_BITS),
		.ENTRIES (DEPTH),
		.AW      (AW)
	) u_right_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (accept),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	assign top_value = l_rdata[LW-1 -: VALUE_BITS];
	assign top_sum   = l_rdata[2*SW-1 -: SW];
	assign top_best  = l_rdata[SW-1:0];

	// move right pushes the popped right value, insert pushes the command value
	assign push_value = (cmd_s1 == CMD_RIGHT) ? $signed(r_rdata) : value_s1;

	cbpm_push_calc #(
		.VALUE_BITS (VALUE_BITS),
		.SW         (SW)
	) u_push_calc (
		.push_value (push_value),
		.has_prev   (has_prev_s1),
		.prev_sum   (top_sum),
		.prev_best  (top_best),
		.new_sum    (new_sum),
		.new_best   (new_best)
	);

	assign do_op = ctl.exec && (stat_s1 == STAT_DONE);

	// counts are untouched between accept and execute, so they still address
	// the top slots here
	always_comb begin
		l_we    = do_op && ((cmd_s1 == CMD_INSERT) || (cmd_s1 == CMD_RIGHT));
		l_waddr = lc_q[AW-1:0];
		l_wdata = {push_value, new_sum, new_best};
		r_we    = do_op && (cmd_s1 == CMD_LEFT);
		r_waddr = rc_q[AW-1:0];
		r_wdata = top_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			rc_q <= '0;
		end else if (do_op) begin
			case (cmd_s1)
				CMD_INSERT: lc_q <= lc_q + CW'(1);
				CMD_DELETE: lc_q <= lc_q - CW'(1);
				CMD_LEFT: begin
					lc_q <= lc_q - CW'(1);
					rc_q <= rc_q + CW'(1);
				end
				CMD_RIGHT: begin
					lc_q <= lc_q + CW'(1);
					rc_q <= rc_q - CW'(1);
				end
				default: begin
					lc_q <= lc_q;
					rc_q <= rc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q     <= stat_s1;
			max_prefix_q <= (stat_s1 == STAT_ANSWER) ? top_best[SUM_BITS-1:0] : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign max_prefix = max_prefix_q;

endmodule
